[hw/rtl/msd_pkg.sv]
package msd_pkg;

  localparam logic [7:0] SymDot  = 8'h2E;
  localparam logic [7:0] SymDash = 8'h2D;
  localparam logic [7:0] SymSep  = 8'h2F;

  localparam logic [2:0] MaxSymbols = 3'd5;

  localparam logic [7:0] LetterBase = 8'd65;
  localparam logic [7:0] DigitBase  = 8'd48;
  localparam logic [7:0] NoChar     = 8'd0;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // completed token handed from front to back
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
    logic       invalid;
    logic       last;
    logic       is_sep;
  } tok_entry_t;

  // first symbol in the highest used bit, dash is 1
  function automatic logic [7:0] lookup_char(input logic [2:0] len, input logic [4:0] bits);
    logic [7:0] ch;
    ch = NoChar;
    unique case ({len, bits})
      {3'd2, 5'b00001}: ch = LetterBase + 8'd0;
      {3'd4, 5'b01000}: ch = LetterBase + 8'd1;
      {3'd4, 5'b01010}: ch = LetterBase + 8'd2;
      {3'd3, 5'b00100}: ch = LetterBase + 8'd3;
      {3'd1, 5'b00000}: ch = LetterBase + 8'd4;
      {3'd4, 5'b00010}: ch = LetterBase + 8'd5;
      {3'd3, 5'b00110}: ch = LetterBase + 8'd6;
      {3'd4, 5'b00000}: ch = LetterBase + 8'd7;
      {3'd2, 5'b00000}: ch = LetterBase + 8'd8;
      {3'd4, 5'b00111}: ch = LetterBase + 8'd9;
      {3'd3, 5'b00101}: ch = LetterBase + 8'd10;
      {3'd4, 5'b00100}: ch = LetterBase + 8'd11;
      {3'd2, 5'b00011}: ch = LetterBase + 8'd12;
      {3'd2, 5'b00010}: ch = LetterBase + 8'd13;
      {3'd3, 5'b00111}: ch = LetterBase + 8'd14;
      {3'd4, 5'b00110}: ch = LetterBase + 8'd15;
      {3'd4, 5'b01101}: ch = LetterBase + 8'd16;
      {3'd3, 5'b00010}: ch = LetterBase + 8'd17;
      {3'd3, 5'b00000}: ch = LetterBase + 8'd18;
      {3'd1, 5'b00001}: ch = LetterBase + 8'd19;
      {3'd3, 5'b00001}: ch = LetterBase + 8'd20;
      {3'd4, 5'b00001}: ch = LetterBase + 8'd21;
      {3'd3, 5'b00011}: ch = LetterBase + 8'd22;
      {3'd4, 5'b01001}: ch = LetterBase + 8'd23;
      {3'd4, 5'b01011}: ch = LetterBase + 8'd24;
      {3'd4, 5'b01100}: ch = LetterBase + 8'd25;
      {3'd5, 5'b11111}: ch = DigitBase + 8'd0;
      {3'd5, 5'b01111}: ch = DigitBase + 8'd1;
      {3'd5, 5'b00111}: ch = DigitBase + 8'd2;
      {3'd5, 5'b00011}: ch = DigitBase + 8'd3;
      {3'd5, 5'b00001}: ch = DigitBase + 8'd4;
      {3'd5, 5'b00000}: ch = DigitBase + 8'd5;
      {3'd5, 5'b10000}: ch = DigitBase + 8'd6;
      {3'd5, 5'b11000}: ch = DigitBase + 8'd7;
      {3'd5, 5'b11100}: ch = DigitBase + 8'd8;
      {3'd5, 5'b11110}: ch = DigitBase + 8'd9;
      default:          ch = NoChar;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/msd_front.sv]
module msd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_code,
  input  logic                 in_last,
  input  logic                 q_full,
  output logic                 q_push,
  output msd_pkg::tok_entry_t  q_data
);

  logic [2:0] len_r, len_nxt;
  logic [4:0] bits_r, bits_nxt;
  logic       inv_r, inv_nxt;
  logic       accept;
  logic       is_dot, is_dash, is_sep;
  logic [2:0] upd_len;
  logic [4:0] upd_bits;
  logic       upd_inv;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_dot  = (in_char_code == msd_pkg::SymDot);
  assign is_dash = (in_char_code == msd_pkg::SymDash);
  assign is_sep  = (in_char_code == msd_pkg::SymSep);

  // token after this byte joins it
  always_comb begin
    upd_len  = len_r;
    upd_bits = bits_r;
    upd_inv  = inv_r;
    if (!is_sep) begin
      if (is_dot || is_dash) begin
        if (len_r >= msd_pkg::MaxSymbols) begin
          upd_inv = 1'b1;
        end else begin
          upd_bits = {bits_r[3:0], is_dash};
          upd_len  = len_r + 3'd1;
        end
      end else begin
        upd_inv = 1'b1;
      end
    end
  end

  assign q_push         = accept && (is_sep || in_last);
  assign q_data.len     = upd_len;
  assign q_data.bits    = upd_bits;
  assign q_data.invalid = upd_inv;
  assign q_data.last    = in_last;
  assign q_data.is_sep  = is_sep;

  always_comb begin
    len_nxt  = len_r;
    bits_nxt = bits_r;
    inv_nxt  = inv_r;
    if (accept) begin
      if (is_sep || in_last) begin
        len_nxt  = 3'd0;
        bits_nxt = 5'd0;
        inv_nxt  = 1'b0;
      end else begin
        len_nxt  = upd_len;
        bits_nxt = upd_bits;
        inv_nxt  = upd_inv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 3'd0;
      bits_r <= 5'd0;
      inv_r  <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      bits_r <= bits_nxt;
      inv_r  <= inv_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= msd_pkg::MaxSymbols)
    else $error("token length beyond five symbols");

endmodule

[hw/rtl/msd_queue.sv]
module msd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  msd_pkg::tok_entry_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output msd_pkg::tok_entry_t  pop_data
);

  msd_pkg::tok_entry_t mem [msd_pkg::QDepth];

  logic [msd_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [msd_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [msd_pkg::QCntW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == msd_pkg::QCntW'(msd_pkg::QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  function automatic logic [msd_pkg::QPtrW-1:0] ptr_inc(input logic [msd_pkg::QPtrW-1:0] p);
    logic [msd_pkg::QPtrW-1:0] r;
    if (p == msd_pkg::QPtrW'(msd_pkg::QDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

[hw/rtl/msd_back.sv]
module msd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  msd_pkg::tok_entry_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_has_char,
  output logic [7:0]           out_decoded_char,
  output logic                 out_message_end,
  output logic                 out_message_error
);

  logic       valid_r, valid_nxt;
  logic       has_r;
  logic [7:0] char_r;
  logic       end_r;
  logic       err_r;
  logic [7:0] ch;
  logic       emit;

  always_comb begin
    if (q_data.invalid) begin
      ch = msd_pkg::NoChar;
    end else begin
      ch = msd_pkg::lookup_char(q_data.len, q_data.bits);
    end
  end

  assign emit  = q_data.last || (ch != msd_pkg::NoChar);
  assign q_pop = !q_empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = emit;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      has_r  <= (ch != msd_pkg::NoChar);
      char_r <= ch;
      end_r  <= q_data.last;
      err_r  <= q_data.last && q_data.is_sep;
    end
  end

  assign out_valid         = valid_r;
  assign out_has_char      = has_r;
  assign out_decoded_char  = char_r;
  assign out_message_end   = end_r;
  assign out_message_error = err_r;

  a_char_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (has_r == (char_r != msd_pkg::NoChar)))
    else $error("has_char disagrees with decoded_char");

  a_err_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && err_r) |-> end_r)
    else $error("message_error without message_end");

  a_result_useful: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (has_r || end_r))
    else $error("empty result emitted");

endmodule

[hw/rtl/morse_stream_decoder.sv]
// morse stream decoder
// input channel: one byte of morse text per transfer on in_char_code, with
// in_last marking the final byte of a message. '.' and '-' are symbols and
// '/' ends a letter; any other byte spoils the current token.
// output channel: at most one result per input byte. a separator that
// closes a matching token gives out_has_char with the ascii letter or
// digit; the last byte of a message always gives a result with
// out_message_end, plus out_message_error when that byte was '/'.
// throughput is one byte per cycle while in_stall is low; the front updates
// the token and the back does the table match, one item per cycle each
// while not stalled. a closed token is registered in the two-entry token
// queue and then in the output register before its result is valid.
// when the receiver stalls, the output register holds its result and the
// queue fills; in_stall rises once the queue is full and drops as soon as
// an entry leaves it.
// a synchronous reset (rst_n low) clears the token, empties the queue and
// drops out_valid.
module morse_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_char,
  output logic [7:0] out_decoded_char,
  output logic       out_message_end,
  output logic       out_message_error
);

  msd_pkg::tok_entry_t push_data;
  msd_pkg::tok_entry_t pop_data;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  msd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  msd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  msd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (empty),
    .q_data            (pop_data),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_has_char      (out_has_char),
    .out_decoded_char  (out_decoded_char),
    .out_message_end   (out_message_end),
    .out_message_error (out_message_error)
  );

endmodule
